[rtl/matrix_rotate_flip_transpose_assert.svh]
// Assertion macros used by the checker of this block.
`ifndef MATRIX_ROTATE_FLIP_TRANSPOSE_ASSERT_SVH
`define MATRIX_ROTATE_FLIP_TRANSPOSE_ASSERT_SVH

// Same-cycle implication, sampled at clk, off during reset.
`define MRFT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrft assertion failed");

// Next-cycle implication, sampled at clk, off during reset.
`define MRFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrft assertion failed");

`endif

[rtl/mrft_pkg.sv]
package mrft_pkg;

  localparam int ELEM_W     = 8;
  localparam int MODE_W     = 3;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam logic [SIZE_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [SIZE_W-1:0] COLS_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDENT     = 3'd0,
    MODE_TRANSPOSE = 3'd1,
    MODE_ROT_CCW   = 3'd2,
    MODE_ROT180    = 3'd3,
    MODE_ROT_CW    = 3'd4,
    MODE_FLIP_H    = 3'd5,
    MODE_FLIP_V    = 3'd6
  } mode_t;

endpackage

[rtl/mrft_frame_ram.sv]
module mrft_frame_ram
  import mrft_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [ELEM_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [ELEM_W-1:0] rd_data
);

  logic [ELEM_W-1:0] mem [DEPTH];
  logic [ELEM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/matrix_rotate_flip_transpose.sv]
// A read is registered in stage 1 and the RAM, then in the output register.
// Throughput: one beat per cycle, load or read, while in_tready is high, set by
// the single RAM access at accept; a stalled output holds one extra result.
// Reset: clears load count, read position, pipeline valids and registers to
// mode 0, 64 by 64; the frame store is not cleared and reads report not_ready
// until a full frame is loaded.
module matrix_rotate_flip_transpose
  import mrft_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [ELEM_W-1:0]     in_tdata,   // [7:0] element_in
  input  logic                  in_tuser,   // [0] func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [ELEM_W-1:0]     out_tdata,  // [7:0] element_out
  output logic                  out_tlast,
  output logic [1:0]            out_tuser,  // [0] row_end, [1] status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LCW     = $clog2(DEPTH + 1);
  localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int SZW     = $clog2(MAX_DIM + 1);
  localparam int IW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PW      = 2 * SZW;

  logic [MODE_W-1:0] mode_r;
  logic [SIZE_W-1:0] rows_cfg_r;
  logic [SIZE_W-1:0] cols_cfg_r;

  logic [LCW-1:0] load_count_r, load_count_nxt;
  logic [IW-1:0]  outer_r, outer_nxt;
  logic [IW-1:0]  inner_r, inner_nxt;

  logic s1_valid_r, s1_valid_nxt;
  logic s1_status_r, s1_row_end_r, s1_last_r;
  logic out_valid_r;
  logic [ELEM_W-1:0] out_data_r;
  logic out_row_end_r, out_last_r, out_status_r;

  logic [SZW-1:0] rows, cols, rows_m1, cols_m1;
  logic [SZW-1:0] outer_len, inner_len, outer_m1, inner_m1;
  logic [SZW-1:0] o_sz, i_sz, r_sz, c_sz;
  logic [PW-1:0]  total, addr_full;
  mode_t          mode_eff;
  logic           swap, frame_full, pos_bad, row_end, last;
  logic           in_fire, ld_fire, rd_fire, s1_adv;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [ELEM_W-1:0] ram_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDENT;
      rows_cfg_r <= ROWS_RESET;
      cols_cfg_r <= COLS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_MODE: mode_r     <= cfg_data[MODE_W-1:0];
        CFG_ROWS: rows_cfg_r <= cfg_data[SIZE_W-1:0];
        CFG_COLS: cols_cfg_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_cfg_r == '0) begin
      rows = SZW'(1);
    end else if (32'(rows_cfg_r) > 32'(MAX_ROWS)) begin
      rows = SZW'(MAX_ROWS);
    end else begin
      rows = SZW'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      cols = SZW'(1);
    end else if (32'(cols_cfg_r) > 32'(MAX_COLS)) begin
      cols = SZW'(MAX_COLS);
    end else begin
      cols = SZW'(cols_cfg_r);
    end
  end

  assign rows_m1  = rows - SZW'(1);
  assign cols_m1  = cols - SZW'(1);
  assign mode_eff = (mode_r > MODE_W'(MODE_FLIP_V)) ? MODE_IDENT : mode_t'(mode_r);
  assign swap     = (mode_eff == MODE_TRANSPOSE) || (mode_eff == MODE_ROT_CCW) ||
                    (mode_eff == MODE_ROT_CW);
  assign outer_len = swap ? cols : rows;
  assign inner_len = swap ? rows : cols;
  assign outer_m1  = outer_len - SZW'(1);
  assign inner_m1  = inner_len - SZW'(1);

  assign total      = PW'(rows) * PW'(cols);
  assign frame_full = 32'(load_count_r) >= 32'(total);

  assign pos_bad = (SZW'(outer_r) >= outer_len) || (SZW'(inner_r) >= inner_len);
  assign o_sz    = pos_bad ? '0 : SZW'(outer_r);
  assign i_sz    = pos_bad ? '0 : SZW'(inner_r);

  always_comb begin
    case (mode_eff)
      MODE_TRANSPOSE: begin r_sz = i_sz;           c_sz = o_sz;           end
      MODE_ROT_CCW:   begin r_sz = i_sz;           c_sz = cols_m1 - o_sz; end
      MODE_ROT180:    begin r_sz = rows_m1 - o_sz; c_sz = cols_m1 - i_sz; end
      MODE_ROT_CW:    begin r_sz = rows_m1 - i_sz; c_sz = o_sz;           end
      MODE_FLIP_H:    begin r_sz = o_sz;           c_sz = cols_m1 - i_sz; end
      MODE_FLIP_V:    begin r_sz = rows_m1 - o_sz; c_sz = i_sz;           end
      default:        begin r_sz = o_sz;           c_sz = i_sz;           end
    endcase
  end

  assign addr_full = PW'(r_sz) * PW'(cols) + PW'(c_sz);
  assign rd_addr   = addr_full[AW-1:0];
  assign row_end   = (i_sz == inner_m1);
  assign last      = row_end && (o_sz == outer_m1);

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;
  assign ld_fire   = in_fire && (in_tuser == FUNC_LOAD);
  assign rd_fire   = in_fire && (in_tuser == FUNC_READ);
  assign wr_addr   = frame_full ? '0 : load_count_r[AW-1:0];

  always_comb begin
    load_count_nxt = load_count_r;
    outer_nxt      = outer_r;
    inner_nxt      = inner_r;
    if (ld_fire) begin
      if (frame_full) begin
        load_count_nxt = LCW'(1);
        outer_nxt      = '0;
        inner_nxt      = '0;
      end else begin
        load_count_nxt = load_count_r + LCW'(1);
      end
    end else if (rd_fire && frame_full) begin
      if (last) begin
        outer_nxt = '0;
        inner_nxt = '0;
      end else if (row_end) begin
        outer_nxt = IW'(o_sz + SZW'(1));
        inner_nxt = '0;
      end else begin
        outer_nxt = IW'(o_sz);
        inner_nxt = IW'(i_sz + SZW'(1));
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (rd_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      outer_r      <= '0;
      inner_r      <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      load_count_r <= load_count_nxt;
      outer_r      <= outer_nxt;
      inner_r      <= inner_nxt;
      s1_valid_r   <= s1_valid_nxt;
      if (s1_valid_r && s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) begin
      s1_status_r  <= !frame_full;
      s1_row_end_r <= frame_full && row_end;
      s1_last_r    <= frame_full && last;
    end
    if (s1_valid_r && s1_adv) begin
      out_data_r    <= s1_status_r ? '0 : ram_q;
      out_row_end_r <= s1_row_end_r;
      out_last_r    <= s1_last_r;
      out_status_r  <= s1_status_r;
    end
  end

  mrft_frame_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ld_fire),
    .wr_addr (wr_addr),
    .wr_data (in_tdata),
    .rd_en   (rd_fire && frame_full),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_status_r, out_row_end_r};

endmodule

[rtl/mrft_checker.sv]
`include "matrix_rotate_flip_transpose_assert.svh"

module mrft_checker
  import mrft_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [ELEM_W-1:0]     out_tdata,  // [7:0] element_out
  input logic                  out_tlast,
  input logic [1:0]            out_tuser   // [0] row_end, [1] status
);

  logic [ELEM_W+2:0] out_beat;

  assign out_beat = {out_tuser, out_tlast, out_tdata};

  `MRFT_ASSERT_NEXT(a_out_hold_valid, out_tvalid && !out_tready, out_tvalid)
  `MRFT_ASSERT_NEXT(a_out_hold_data, out_tvalid && !out_tready, $stable(out_beat))
  `MRFT_ASSERT_IMPL(a_not_ready_zero, out_tvalid && out_tuser[1], out_tdata == '0 && !out_tlast && !out_tuser[0])
  `MRFT_ASSERT_IMPL(a_last_ends_row, out_tvalid && out_tlast, out_tuser[0])

endmodule

bind matrix_rotate_flip_transpose mrft_checker u_mrft_checker (.*);
